@@ hdl/wcsq_pkg.sv @@
// shared types and constants of the windowed chi-square quadratic form core
package wcsq_pkg;

  localparam int MAX_BINS = 64;
  localparam int ADDR_W = $clog2(MAX_BINS);

  localparam int IDX_W = 6;
  localparam int CNT_W = 20;
  localparam int DIFF_W = CNT_W + 1;
  localparam int WIN_W = 7;
  localparam int MAT_W = 32;
  localparam int ACC_W = 64;
  localparam int PROD_W = 2 * CNT_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ELEM   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_LEN   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MAG,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic write_bin;
    logic latch_elem;
    logic emit;
    logic read;
    logic square;
    logic mul_lo;
    logic mul_hi;
    logic mag;
    logic accumulate;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

@@ hdl/wcsq_ctrl.sv @@
// sequencer for bin loads, matrix element terms and result emission
module wcsq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  wcsq_pkg::status_t status,
  output wcsq_pkg::cmd_t    cmd
);

  wcsq_pkg::state_t state;
  wcsq_pkg::state_t state_next;
  logic             accept;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wcsq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // an item waits while a term is in flight; a finish item also waits while the previous result is still held
  assign in_ready = (state == wcsq_pkg::ST_IDLE) &&
                    !(mode == wcsq_pkg::MODE_FINISH && out_valid && !out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      wcsq_pkg::ST_IDLE: begin
        if (accept && mode == wcsq_pkg::MODE_ELEM && status.hit) begin
          state_next = wcsq_pkg::ST_READ;
        end
      end
      wcsq_pkg::ST_READ:   state_next = wcsq_pkg::ST_SQUARE;
      wcsq_pkg::ST_SQUARE: state_next = wcsq_pkg::ST_MUL_LO;
      wcsq_pkg::ST_MUL_LO: state_next = wcsq_pkg::ST_MUL_HI;
      wcsq_pkg::ST_MUL_HI: state_next = wcsq_pkg::ST_MAG;
      wcsq_pkg::ST_MAG:    state_next = wcsq_pkg::ST_ACC;
      wcsq_pkg::ST_ACC:    state_next = wcsq_pkg::ST_IDLE;
      default:             state_next = wcsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.write_bin  = accept && mode == wcsq_pkg::MODE_LOAD;
    cmd.latch_elem = accept && mode == wcsq_pkg::MODE_ELEM;
    cmd.emit       = accept && mode == wcsq_pkg::MODE_FINISH;
    unique case (state)
      wcsq_pkg::ST_READ:   cmd.read       = 1'b1;
      wcsq_pkg::ST_SQUARE: cmd.square     = 1'b1;
      wcsq_pkg::ST_MUL_LO: cmd.mul_lo     = 1'b1;
      wcsq_pkg::ST_MUL_HI: cmd.mul_hi     = 1'b1;
      wcsq_pkg::ST_MAG:    cmd.mag        = 1'b1;
      wcsq_pkg::ST_ACC:    cmd.accumulate = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == wcsq_pkg::ST_IDLE)
    else $error("input taken while a term is in flight");

  a_hit_starts_term: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == wcsq_pkg::MODE_ELEM && status.hit) |=> state == wcsq_pkg::ST_READ)
    else $error("windowed element did not start a term");

  a_acc_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == wcsq_pkg::ST_ACC |=> state == wcsq_pkg::ST_IDLE)
    else $error("term did not finish after accumulation");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("finish item gave no result");

endmodule

@@ hdl/wcsq_dp.sv @@
// difference store, window check, term multiplier and saturating accumulator
module wcsq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wcsq_pkg::cmd_t                       cmd,
  output wcsq_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic [wcsq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wcsq_pkg::WIN_W-1:0]           cfg_data,
  input  logic [wcsq_pkg::IDX_W-1:0]           bin_index,
  input  logic [wcsq_pkg::CNT_W-1:0]           data_value,
  input  logic [wcsq_pkg::CNT_W-1:0]           model_value,
  input  logic [wcsq_pkg::IDX_W-1:0]           row,
  input  logic [wcsq_pkg::IDX_W-1:0]           col,
  input  logic signed [wcsq_pkg::MAT_W-1:0]    matrix_value,
  output logic signed [wcsq_pkg::ACC_W-1:0]    chi_square,
  output logic                                 saturated
);

  localparam int DW = wcsq_pkg::DIFF_W;
  localparam int AW = wcsq_pkg::ADDR_W;
  localparam int PW = wcsq_pkg::PROD_W;
  localparam int MW = wcsq_pkg::MAT_W;
  localparam int CW = wcsq_pkg::ACC_W;
  localparam int WW = wcsq_pkg::WIN_W;

  logic [WW-1:0]        window_start;
  logic [WW-1:0]        window_len;

  logic signed [DW-1:0] diff_mem [wcsq_pkg::MAX_BINS];
  logic signed [DW-1:0] di;
  logic signed [DW-1:0] dj;

  logic [WW-1:0]        rel_row;
  logic [WW-1:0]        rel_col;
  logic                 row_in;
  logic                 col_in;

  logic [AW-1:0]        li;
  logic [AW-1:0]        lj;
  logic [MW-1:0]        b_mag;
  logic                 m_neg;
  logic [PW-1:0]        a_mag;
  logic                 neg;
  logic [2*MW-1:0]      plo;
  logic [2*MW-1:0]      phi;
  logic [CW-1:0]        mag;

  logic [MW-1:0]        mul_a;
  logic [2*MW-1:0]      mul_p;
  logic [DW-2:0]        abs_i;
  logic [DW-2:0]        abs_j;

  logic signed [CW-1:0] acc;
  logic                 sat;
  logic signed [CW:0]   acc_sum;
  logic                 acc_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_len   <= WW'(wcsq_pkg::MAX_BINS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcsq_pkg::REG_WINDOW_START: window_start <= cfg_data;
        wcsq_pkg::REG_WINDOW_LEN:   window_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // window test on global indices, local index is the offset from the start
  assign rel_row = WW'(row) - window_start;
  assign rel_col = WW'(col) - window_start;
  assign row_in  = (WW'(row) >= window_start) && (rel_row < window_len) &&
                   (32'(rel_row) < wcsq_pkg::MAX_BINS);
  assign col_in  = (WW'(col) >= window_start) && (rel_col < window_len) &&
                   (32'(rel_col) < wcsq_pkg::MAX_BINS);
  assign status.hit = row_in && col_in;

  always_ff @(posedge clk) begin
    if (cmd.write_bin && 32'(bin_index) < wcsq_pkg::MAX_BINS) begin
      diff_mem[AW'(bin_index)] <= $signed({1'b0, data_value}) - $signed({1'b0, model_value});
    end
    if (cmd.read) begin
      di <= diff_mem[li];
      dj <= diff_mem[lj];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_elem) begin
      li    <= AW'(rel_row);
      lj    <= AW'(rel_col);
      m_neg <= matrix_value[MW-1];
      b_mag <= matrix_value[MW-1] ? (~matrix_value + 1'b1) : matrix_value;
    end
  end

  assign abs_i = di[DW-1] ? (DW-1)'(-di) : di[DW-2:0];
  assign abs_j = dj[DW-1] ? (DW-1)'(-dj) : dj[DW-2:0];

  // one 32x32 multiplier serves both halves of the difference product
  assign mul_a = cmd.mul_hi ? MW'(a_mag[PW-1:MW]) : a_mag[MW-1:0];
  assign mul_p = mul_a * b_mag;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      a_mag <= PW'(abs_i) * PW'(abs_j);
      neg   <= di[DW-1] ^ dj[DW-1] ^ m_neg;
    end
    if (cmd.mul_lo) begin
      plo <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi <= mul_p;
      plo <= plo + (2*MW)'(128);   // round half away from zero on the magnitude
    end
    if (cmd.mag) begin
      mag <= CW'((phi << 24) + (plo >> 8));
    end
  end

  assign acc_sum = neg ? ({acc[CW-1], acc} - $signed({1'b0, mag}))
                       : ({acc[CW-1], acc} + $signed({1'b0, mag}));
  assign acc_ovf = acc_sum[CW] != acc_sum[CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (cmd.emit) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (cmd.accumulate) begin
      if (acc_ovf) begin
        acc <= acc_sum[CW] ? wcsq_pkg::ACC_MIN : wcsq_pkg::ACC_MAX;
        sat <= 1'b1;
      end else begin
        acc <= acc_sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chi_square <= acc;
      saturated  <= sat;
    end
  end

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (sat && !cmd.emit) |=> sat)
    else $error("saturation flag dropped before finish");

  a_ovf_sets_sat: assert property (@(posedge clk) disable iff (rst)
    (cmd.accumulate && acc_ovf && !cmd.emit) |=> sat &&
      (acc == wcsq_pkg::ACC_MAX || acc == wcsq_pkg::ACC_MIN))
    else $error("overflow did not clamp the accumulator");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> acc == '0 && !sat)
    else $error("finish did not clear the accumulator");

endmodule

@@ hdl/windowed_chi_square_quadratic_form_core.sv @@
// Windowed chi-square quadratic form core: load-bin items (mode 0) store data minus model and
// do not hold the input; matrix-element items (mode 1) outside the window do not hold it either,
// while an element inside the window holds the input until its term reaches the accumulator
// through the difference-store read, the difference product and the two passes of the shared
// 32x32 multiplier over the halves of that product, then rounding and the saturating 64-bit add;
// a finish item (mode 2) loads the output register and waits while a term is in flight or
// while the previous result is still held there. Configuration writes are taken in any
// cycle but must only be made while the core is idle.
module windowed_chi_square_quadratic_form_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic [wcsq_pkg::IDX_W-1:0]           bin_index,
  input  logic [wcsq_pkg::CNT_W-1:0]           data_value,
  input  logic [wcsq_pkg::CNT_W-1:0]           model_value,
  input  logic [wcsq_pkg::IDX_W-1:0]           row,
  input  logic [wcsq_pkg::IDX_W-1:0]           col,
  input  logic signed [wcsq_pkg::MAT_W-1:0]    matrix_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wcsq_pkg::ACC_W-1:0]    chi_square,
  output logic                                 saturated,
  input  logic                                 cfg_we,
  input  logic [wcsq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wcsq_pkg::WIN_W-1:0]           cfg_data
);

  wcsq_pkg::cmd_t    cmd;
  wcsq_pkg::status_t status;

  wcsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wcsq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bin_index    (bin_index),
    .data_value   (data_value),
    .model_value  (model_value),
    .row          (row),
    .col          (col),
    .matrix_value (matrix_value),
    .chi_square   (chi_square),
    .saturated    (saturated)
  );

endmodule

@@ tb/tb_top.sv @@
// testbench for the windowed chi-square quadratic form core: directed table, then random phases
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_BINS  = wcsq_pkg::MAX_BINS;
  localparam int IDX_W     = wcsq_pkg::IDX_W;
  localparam int CNT_W     = wcsq_pkg::CNT_W;
  localparam int DIFF_W    = wcsq_pkg::DIFF_W;
  localparam int WIN_W     = wcsq_pkg::WIN_W;
  localparam int MAT_W     = wcsq_pkg::MAT_W;
  localparam int ACC_W     = wcsq_pkg::ACC_W;
  localparam int CFG_IDX_W = wcsq_pkg::CFG_IDX_W;
  localparam logic [ACC_W-1:0] ACC_MAX = wcsq_pkg::ACC_MAX;
  localparam logic [ACC_W-1:0] ACC_MIN = wcsq_pkg::ACC_MIN;

  typedef struct packed {
    wcsq_pkg::mode_t  mode;
    logic [IDX_W-1:0] bin;
    logic [CNT_W-1:0] data_v;
    logic [CNT_W-1:0] model_v;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [MAT_W-1:0] mat;
  } item_t;

  typedef struct packed {
    logic [ACC_W-1:0] chi;
    logic             sat;
  } sum_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    item_t              it;
    logic               typed;
    sum_t               want;
    wcsq_pkg::reg_idx_t reg_sel;
    logic [WIN_W-1:0]   reg_val;
  } plan_row_t;

  localparam logic signed [ACC_W+1:0] WIDE_MAX = $signed({2'b00, ACC_MAX});
  localparam logic signed [ACC_W+1:0] WIDE_MIN = $signed({2'b11, ACC_MIN});

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              mode = wcsq_pkg::MODE_NONE;
  logic [IDX_W-1:0]        bin_index = '0;
  logic [CNT_W-1:0]        data_value = '0;
  logic [CNT_W-1:0]        model_value = '0;
  logic [IDX_W-1:0]        row = '0;
  logic [IDX_W-1:0]        col = '0;
  logic signed [MAT_W-1:0] matrix_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [ACC_W-1:0] chi_square;
  logic                    saturated;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [WIN_W-1:0]        cfg_data = '0;

  windowed_chi_square_quadratic_form_core uut (.*);

  // own copy of the core state
  logic signed [DIFF_W-1:0] bin_diff [MAX_BINS];
  bit                       bin_loaded [MAX_BINS];
  logic signed [ACC_W-1:0]  chi_acc;
  bit                       chi_sat;
  logic [WIN_W-1:0]         win_start;
  logic [WIN_W-1:0]         win_len;

  sum_t pending_sums [$];
  bit   calm;
  int   n_errors, n_loads, n_terms, n_finishes, n_ignored, n_cfg, n_results, n_sat_results;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL windowed_chi_square_quadratic_form_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < 50) $display("mismatch %0s: got %h expected %h at %0t", what, got, want,
                                $time);
    n_errors++;
  endtask

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // global index to local bin, if it falls inside the current window
  function automatic bit to_local(input logic [IDX_W-1:0] g, output int loc);
    int off;
    off = int'(g) - int'(win_start);
    loc = off;
    return off >= 0 && off < int'(win_len) && off < MAX_BINS;
  endfunction

  function automatic bit reads_unloaded(input item_t it, output int miss);
    int li, lj;
    miss = 0;
    if (it.mode != wcsq_pkg::MODE_ELEM || !to_local(it.r, li) || !to_local(it.c, lj)) return 0;
    if (!bin_loaded[li]) begin
      miss = li;
      return 1;
    end
    if (!bin_loaded[lj]) begin
      miss = lj;
      return 1;
    end
    return 0;
  endfunction

  // magnitude of one term in Q.16, rounded half away from zero
  function automatic logic [ACC_W-1:0] term_mag(input logic signed [DIFF_W-1:0] di,
                                                input logic signed [DIFF_W-1:0] dj,
                                                input logic signed [MAT_W-1:0] m,
                                                output bit neg);
    logic signed [2*DIFF_W-1:0]       dd;
    logic signed [2*DIFF_W+MAT_W-1:0] full;
    logic [2*DIFF_W+MAT_W-1:0]        absval;
    dd = di * dj;
    full = dd * m;
    neg = full < 0;
    absval = neg ? -full : full;
    return ACC_W'((absval + 128) >> 8);
  endfunction

  task automatic predict_chi(input item_t it, output bit emits, output sum_t s);
    int                      li, lj;
    bit                      neg;
    logic [ACC_W-1:0]        mag;
    logic signed [ACC_W+1:0] wide;
    emits = 0;
    s = '0;
    case (it.mode)
      wcsq_pkg::MODE_LOAD: begin
        bin_diff[it.bin] = $signed({1'b0, it.data_v}) - $signed({1'b0, it.model_v});
        bin_loaded[it.bin] = 1;
        n_loads++;
      end
      wcsq_pkg::MODE_ELEM: begin
        if (to_local(it.r, li) && to_local(it.c, lj)) begin
          mag = term_mag(bin_diff[li], bin_diff[lj], it.mat, neg);
          wide = neg ? chi_acc - $signed({2'b00, mag}) : chi_acc + $signed({2'b00, mag});
          if (wide > WIDE_MAX) begin
            chi_acc = ACC_MAX;
            chi_sat = 1;
          end else if (wide < WIDE_MIN) begin
            chi_acc = ACC_MIN;
            chi_sat = 1;
          end else begin
            chi_acc = wide[ACC_W-1:0];
          end
          n_terms++;
        end else begin
          n_ignored++;
        end
      end
      wcsq_pkg::MODE_FINISH: begin
        emits = 1;
        s.chi = chi_acc;
        s.sat = chi_sat;
        chi_acc = '0;
        chi_sat = 0;
        n_finishes++;
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic logic [CNT_W-1:0] rand_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? '1 : '0;
      1: return CNT_W'($urandom_range(0, 64));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [MAT_W-1:0] rand_matrix();
    logic [MAT_W-1:0] m;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: m = 32'h7FFF_FFFF;
          1: m = 32'h8000_0000;
          2: m = '0;
          3: m = '1;
          default: m = 32'h0000_0001;
        endcase
      end
      // around plus or minus one in Q8.24
      1: begin
        m = $urandom_range(0, 32'h0200_0000);
        if ($urandom_range(0, 1)) m = -m;
      end
      default: m = $urandom;
    endcase
    return m;
  endfunction

  function automatic item_t rand_item(input wcsq_pkg::mode_t md);
    item_t it;
    it.mode = md;
    it.bin = IDX_W'($urandom);
    it.data_v = CNT_W'($urandom);
    it.model_v = CNT_W'($urandom);
    it.r = IDX_W'($urandom);
    it.c = IDX_W'($urandom);
    it.mat = $urandom;
    return it;
  endfunction

  function automatic item_t load_item(input int b, input logic [CNT_W-1:0] d,
                                      input logic [CNT_W-1:0] m);
    item_t it;
    it = rand_item(wcsq_pkg::MODE_LOAD);
    it.bin = IDX_W'(b);
    it.data_v = d;
    it.model_v = m;
    return it;
  endfunction

  function automatic item_t elem_item(input int r, input int c, input logic [MAT_W-1:0] m);
    item_t it;
    it = rand_item(wcsq_pkg::MODE_ELEM);
    it.r = IDX_W'(r);
    it.c = IDX_W'(c);
    it.mat = m;
    return it;
  endfunction

  function automatic plan_row_t as_row(input item_t it);
    plan_row_t p;
    p = '0;
    p.kind = ROW_ITEM;
    p.it = it;
    return p;
  endfunction

  function automatic plan_row_t typed_finish(input logic [ACC_W-1:0] chi, input bit sat);
    plan_row_t p;
    p = as_row(rand_item(wcsq_pkg::MODE_FINISH));
    p.typed = 1'b1;
    p.want.chi = chi;
    p.want.sat = sat;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input wcsq_pkg::reg_idx_t sel, input int val);
    plan_row_t p;
    p = '0;
    p.kind = ROW_CFG;
    p.reg_sel = sel;
    p.reg_val = WIN_W'(val);
    return p;
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send(input item_t it, input bit typed, input sum_t want);
    int   gap;
    bit   emits;
    sum_t s;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    bin_index <= it.bin;
    data_value <= it.data_v;
    model_value <= it.model_v;
    row <= it.r;
    col <= it.c;
    matrix_value <= it.mat;
    do @(posedge clk); while (!in_ready);
    predict_chi(it, emits, s);
    if (emits) pending_sums.insert(pending_sums.size(), typed ? want : s);
  endtask

  // wait for all sums, then let an in-window term finish its pass through the core
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input wcsq_pkg::reg_idx_t sel, input logic [WIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == wcsq_pkg::REG_WINDOW_START) win_start = val;
    else win_len = val;
    n_cfg++;
  endtask

  // result receiver with random stalls
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_sums
    sum_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (saturated) n_sat_results++;
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected sum", chi_square, '0);
      end else begin
        want = pending_sums.pop_front();
        if (chi_square !== want.chi) report_mismatch("chi_square", chi_square, want.chi);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    item_t     it;
    int        miss, span, n, pick, ws, wl, which;
    for (int k = 0; k < MAX_BINS; k++) begin
      bin_diff[k] = '0;
      bin_loaded[k] = 0;
    end
    chi_acc = '0;
    chi_sat = 0;
    win_start = 0;
    win_len = 64;
    calm = 0;

    plan.insert(plan.size(), typed_finish('0, 0));
    plan.insert(plan.size(), as_row(rand_item(wcsq_pkg::MODE_NONE)));
    plan.insert(plan.size(), as_row(load_item(0, 20'hFFFFF, 20'h00000)));
    plan.insert(plan.size(), as_row(load_item(1, 20'h00000, 20'hFFFFF)));
    plan.insert(plan.size(), as_row(load_item(63, 20'h12345, 20'h54321)));
    // largest difference squared twice over saturates high, cross terms saturate low
    plan.insert(plan.size(), as_row(elem_item(0, 0, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), as_row(elem_item(0, 0, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), typed_finish(ACC_MAX, 1));
    plan.insert(plan.size(), as_row(elem_item(0, 1, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), as_row(elem_item(1, 0, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), typed_finish(ACC_MIN, 1));
    plan.insert(plan.size(), as_row(elem_item(0, 0, 32'h8000_0000)));
    plan.insert(plan.size(), as_row(elem_item(1, 63, 32'h0000_0001)));
    plan.insert(plan.size(), as_row(elem_item(63, 63, 32'hFFFF_FFFF)));
    plan.insert(plan.size(), as_row(rand_item(wcsq_pkg::MODE_FINISH)));
    plan.insert(plan.size(), as_row(load_item(2, 20'h00010, 20'h00010)));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_LEN, 0));
    plan.insert(plan.size(), as_row(elem_item(0, 0, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), typed_finish('0, 0));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_START, 1));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_LEN, 1));
    plan.insert(plan.size(), as_row(elem_item(1, 1, 32'h0100_0000)));
    plan.insert(plan.size(), as_row(elem_item(0, 0, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), as_row(elem_item(2, 1, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), as_row(rand_item(wcsq_pkg::MODE_FINISH)));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_START, 64));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_LEN, 64));
    plan.insert(plan.size(), as_row(elem_item(63, 63, 32'h7FFF_FFFF)));
    plan.insert(plan.size(), typed_finish('0, 0));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_START, 0));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_LEN, 127));
    plan.insert(plan.size(), as_row(elem_item(2, 63, 32'h8000_0000)));
    plan.insert(plan.size(), as_row(elem_item(63, 0, 32'h1234_5678)));
    plan.insert(plan.size(), as_row(rand_item(wcsq_pkg::MODE_FINISH)));
    plan.insert(plan.size(), cfg_row(wcsq_pkg::REG_WINDOW_LEN, 64));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        write_reg(plan[k].reg_sel, plan[k].reg_val);
      end else begin
        send(plan[k].it, plan[k].typed, plan[k].want);
      end
    end

    // random phases: maybe a new window, a burst of loads and elements, then a finish
    while (n_loads + n_terms + n_finishes + n_ignored < 1550) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 7))
          0: begin ws = 0; wl = 64; end
          1: begin ws = 0; wl = $urandom_range(1, 32); end
          2: begin ws = $urandom_range(1, 62); wl = $urandom_range(1, 64 - ws); end
          3: begin ws = $urandom_range(0, 127); wl = $urandom_range(0, 127); end
          4: begin ws = 0; wl = 0; end
          5: begin ws = 127; wl = 127; end
          6: begin ws = $urandom_range(32, 63); wl = 127; end
          default: begin ws = 63; wl = 1; end
        endcase
        which = $urandom_range(0, 3);
        if (which != 2) write_reg(wcsq_pkg::REG_WINDOW_START, WIN_W'(ws));
        if (which != 1) write_reg(wcsq_pkg::REG_WINDOW_LEN, WIN_W'(wl));
      end else if ($urandom_range(0, 7) == 0) begin
        drain();
      end
      if (win_start > 63) span = 0;
      else span = (int'(win_len) < 64 - int'(win_start)) ? int'(win_len) : 64 - int'(win_start);
      n = $urandom_range(4, 40);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          if (span > 0 && $urandom_range(0, 1))
            it = load_item($urandom_range(0, span - 1), rand_count(), rand_count());
          else
            it = load_item($urandom_range(0, 63), rand_count(), rand_count());
        end else if (pick < 80 && span > 0) begin
          it = elem_item(win_start + $urandom_range(0, span - 1),
                         win_start + $urandom_range(0, span - 1), rand_matrix());
        end else if (pick < 95) begin
          it = elem_item($urandom_range(0, 63), $urandom_range(0, 63), rand_matrix());
        end else if (pick < 98) begin
          it = rand_item(wcsq_pkg::MODE_NONE);
        end else begin
          it = rand_item(wcsq_pkg::MODE_FINISH);
        end
        // a term may only use bins that hold a difference
        if (reads_unloaded(it, miss)) it = load_item(miss, rand_count(), rand_count());
        send(it, 0, '0);
      end
      send(rand_item(wcsq_pkg::MODE_FINISH), 0, '0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d bin loads, %0d window terms, %0d ignored items, %0d reg writes",
             n_loads, n_terms, n_ignored, n_cfg);
    $display("checked %0d sums, %0d of them saturated", n_results, n_sat_results);
    if (n_errors == 0) begin
      $display("PASS windowed_chi_square_quadratic_form_core");
    end else begin
      $display("FAIL windowed_chi_square_quadratic_form_core");
    end
    $finish;
  end

endmodule

@@ windowed_chi_square_quadratic_form_core.f @@
hdl/wcsq_pkg.sv
hdl/wcsq_ctrl.sv
hdl/wcsq_dp.sv
hdl/windowed_chi_square_quadratic_form_core.sv
tb/tb_top.sv
